@@ hw/rtl/jsu_pkg.sv @@
// Shared types, codes and the UTF-8 encoder for the JSON string unescaper.
package jsu_pkg;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_MISSING = 3'd1,
		ERR_WRONG   = 3'd2,
		ERR_HEX     = 3'd3,
		ERR_TRUNC   = 3'd4
	} err_t;

	typedef enum logic [5:0] {
		MODE_PLAIN  = 6'b000001,
		MODE_ESC    = 6'b000010,
		MODE_HEX_HI = 6'b000100,
		MODE_BSL    = 6'b001000,
		MODE_UESC   = 6'b010000,
		MODE_HEX_LO = 6'b100000
	} mode_t;

	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam int          MAX_RESULTS = 4;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_U     = 8'h75;

	typedef struct packed {
		logic [2:0]                     cnt;
		logic [MAX_RESULTS-1:0][7:0]    bytes;
	} group_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic group_t encode_utf8(input logic [20:0] cp);
		group_t g;
		g.bytes = '0;
		if (cp < 21'h80) begin
			g.cnt      = 3'd1;
			g.bytes[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			g.cnt      = 3'd2;
			g.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
			g.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			g.cnt      = 3'd3;
			g.bytes[0] = 8'hE0 | {4'h0, cp[15:12]};
			g.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
			g.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
		end else begin
			g.cnt      = 3'd4;
			g.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
			g.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
			g.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
			g.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
		end
		return g;
	endfunction

endpackage

@@ hw/rtl/jsu_stream_if.sv @@
// Valid/ready channel interfaces for escaped input bytes and decoded output bytes.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic [2:0] out_error;

	modport source (output valid, output out_byte, output out_last, output out_error,
		input ready);
	modport sink   (input valid, input out_byte, input out_last, input out_error,
		output ready);
endinterface

@@ hw/rtl/json_string_unescape_utf8_core.sv @@
// Streaming JSON string unescaper producing UTF-8 bytes.
//
//   channel   dir   payload                          request
//   in_ch     in    in_byte[7:0], in_last            one raw string byte
//   out_ch    out   out_byte[7:0], out_last,         one decoded byte or
//                   out_error[2:0]                   one error report
//
// One input byte per cycle while the output keeps up: a request waits in the
// input register until the result register is free, then its 0 to 4 results
// load it and drain one byte a cycle while out_ch is ready, stalling input.
// arst_n clears the decode state, the input valid bit and the result register.
// Output stalls back up through the result register into the input register.
module json_string_unescape_utf8_core (
	input  logic         clk,
	input  logic         arst_n,
	jsu_in_if.sink       in_ch,
	jsu_out_if.source    out_ch
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;

	jsu_pkg::mode_t     mode_q;
	logic [1:0]         digit_q;
	logic [15:0]        acc_q;
	logic [9:0]         high_q;
	logic               discard_q;

	jsu_pkg::group_t    grp_q;
	jsu_pkg::err_t      err_q;
	logic [1:0]         idx_q;

	jsu_pkg::mode_t     mode_d;
	logic [1:0]         digit_d;
	logic [15:0]        acc_d;
	logic [9:0]         high_d;
	logic               discard_d;
	jsu_pkg::group_t    grp_d;
	jsu_pkg::err_t      err_d;
	jsu_pkg::hex_t      hex;
	logic [15:0]        acc_sh;

	logic               take;
	logic               out_last_w;
	logic               grp_free;
	logic               adv;

	assign out_last_w = ({1'b0, idx_q} == (grp_q.cnt - 3'd1));
	assign take       = out_ch.valid && out_ch.ready;
	assign grp_free   = (grp_q.cnt == 3'd0) || (take && out_last_w);
	assign adv        = valid_s1 && grp_free;
	assign in_ch.ready = !valid_s1 || grp_free;

	assign out_ch.valid     = (grp_q.cnt != 3'd0);
	assign out_ch.out_byte  = grp_q.bytes[idx_q];
	assign out_ch.out_last  = out_last_w;
	assign out_ch.out_error = err_q;

	assign hex    = jsu_pkg::hex_digit(byte_s1);
	assign acc_sh = {acc_q[11:0], hex.val};

	always_comb begin
		mode_d    = mode_q;
		digit_d   = digit_q;
		acc_d     = acc_q;
		high_d    = high_q;
		discard_d = discard_q;
		grp_d     = '0;
		err_d     = jsu_pkg::ERR_NONE;

		if (discard_q) begin
			if (last_s1) begin
				discard_d = 1'b0;
			end
		end else begin
			case (mode_q)
				jsu_pkg::MODE_ESC: begin
					mode_d = jsu_pkg::MODE_PLAIN;
					grp_d.cnt = 3'd1;
					case (byte_s1)
						jsu_pkg::CH_T:     grp_d.bytes[0] = 8'h09;
						jsu_pkg::CH_B:     grp_d.bytes[0] = 8'h08;
						jsu_pkg::CH_F:     grp_d.bytes[0] = 8'h0C;
						jsu_pkg::CH_N:     grp_d.bytes[0] = 8'h0A;
						jsu_pkg::CH_R:     grp_d.bytes[0] = 8'h0D;
						jsu_pkg::CH_BSL,
						jsu_pkg::CH_SLASH,
						jsu_pkg::CH_QUOTE: grp_d.bytes[0] = byte_s1;
						jsu_pkg::CH_U: begin
							grp_d.cnt = 3'd0;
							acc_d     = '0;
							digit_d   = 2'd0;
							mode_d    = jsu_pkg::MODE_HEX_HI;
						end
						default:           grp_d.cnt = 3'd0;
					endcase
				end
				jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
					if (!hex.ok) begin
						err_d = jsu_pkg::ERR_HEX;
					end else begin
						acc_d = acc_sh;
						if (digit_q != 2'd3) begin
							digit_d = digit_q + 2'd1;
						end else if (mode_q == jsu_pkg::MODE_HEX_HI) begin
							if (acc_sh inside
								{[jsu_pkg::HI_SURR_MIN:jsu_pkg::HI_SURR_MAX]}) begin
								high_d = acc_sh[9:0];
								mode_d = jsu_pkg::MODE_BSL;
							end else begin
								grp_d  = jsu_pkg::encode_utf8({5'b00000, acc_sh});
								mode_d = jsu_pkg::MODE_PLAIN;
							end
						end else begin
							if (acc_sh inside
								{[jsu_pkg::LO_SURR_MIN:jsu_pkg::LO_SURR_MAX]}) begin
								grp_d  = jsu_pkg::encode_utf8(jsu_pkg::SUPP_BASE +
									{1'b0, high_q, acc_sh[9:0]});
								mode_d = jsu_pkg::MODE_PLAIN;
							end else begin
								err_d = jsu_pkg::ERR_WRONG;
							end
						end
					end
				end
				jsu_pkg::MODE_BSL: begin
					if (byte_s1 == jsu_pkg::CH_BSL) begin
						mode_d = jsu_pkg::MODE_UESC;
					end else begin
						err_d = jsu_pkg::ERR_MISSING;
					end
				end
				jsu_pkg::MODE_UESC: begin
					if (byte_s1 == jsu_pkg::CH_U) begin
						acc_d   = '0;
						digit_d = 2'd0;
						mode_d  = jsu_pkg::MODE_HEX_LO;
					end else begin
						err_d = jsu_pkg::ERR_MISSING;
					end
				end
				default: begin
					if (byte_s1 == jsu_pkg::CH_BSL) begin
						mode_d = jsu_pkg::MODE_ESC;
					end else begin
						grp_d.cnt      = 3'd1;
						grp_d.bytes[0] = byte_s1;
					end
				end
			endcase

			if (err_d == jsu_pkg::ERR_NONE && last_s1 && mode_d != jsu_pkg::MODE_PLAIN) begin
				err_d = (mode_d == jsu_pkg::MODE_BSL) ? jsu_pkg::ERR_MISSING
					: jsu_pkg::ERR_TRUNC;
			end

			if (err_d != jsu_pkg::ERR_NONE) begin
				grp_d     = '0;
				grp_d.cnt = 3'd1;
				discard_d = !last_s1;
			end
		end

		if (last_s1 || err_d != jsu_pkg::ERR_NONE) begin
			mode_d  = jsu_pkg::MODE_PLAIN;
			digit_d = 2'd0;
			acc_d   = '0;
			high_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= jsu_pkg::MODE_PLAIN;
			digit_q   <= 2'd0;
			acc_q     <= '0;
			high_q    <= '0;
			discard_q <= 1'b0;
		end else if (adv) begin
			mode_q    <= mode_d;
			digit_q   <= digit_d;
			acc_q     <= acc_d;
			high_q    <= high_d;
			discard_q <= discard_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			err_q <= jsu_pkg::ERR_NONE;
			idx_q <= 2'd0;
		end else if (adv) begin
			grp_q <= grp_d;
			err_q <= err_d;
			idx_q <= 2'd0;
		end else if (take) begin
			if (out_last_w) begin
				grp_q.cnt <= 3'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module testbench;
	import jsu_pkg::*;

	localparam int DIRECTED_N = 27;
	localparam int RANDOM_N   = 470;
	localparam int CYCLE_CAP  = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		err_t       err;
	} dec_byte_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       typed;
		logic [7:0] exp_b;
		err_t       exp_e;
	} item_t;

	logic clk = 1'b0;
	logic arst_n;

	jsu_in_if  in_ch ();
	jsu_out_if out_ch ();

	json_string_unescape_utf8_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #5 clk = ~clk;

	item_t directed [0:DIRECTED_N-1] = '{
		'{8'h00, 1'b0, 1'b1, 8'h00, ERR_NONE},
		'{CH_BSL, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{CH_U, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h44, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h42, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h66, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h46, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{CH_BSL, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{CH_U, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h44, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h46, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h46, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h46, 1'b1, 1'b0, 8'h00, ERR_NONE},
		'{CH_BSL, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{CH_U, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h44, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h38, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h30, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h30, 1'b1, 1'b1, 8'h00, ERR_MISSING},
		'{CH_BSL, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{CH_U, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h67, 1'b0, 1'b1, 8'h00, ERR_HEX},
		'{8'h41, 1'b1, 1'b0, 8'h00, ERR_NONE},
		'{CH_BSL, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{8'h78, 1'b0, 1'b0, 8'h00, ERR_NONE},
		'{CH_BSL, 1'b1, 1'b1, 8'h00, ERR_TRUNC},
		'{8'hFF, 1'b1, 1'b1, 8'hFF, ERR_NONE}
	};

	logic [7:0] esc_set [0:7] = '{CH_T, CH_B, CH_F, CH_N, CH_R, CH_BSL, CH_SLASH, CH_QUOTE};

	item_t     feed [$];
	dec_byte_t utf8_expect [$];
	int        taken;
	int        mismatches;

	mode_t       dec_mode;
	logic [1:0]  digit_cnt;
	logic [15:0] code_acc;
	logic [9:0]  hi_bits;
	logic        dropping;

	function automatic void clear_state();
		dec_mode  = MODE_PLAIN;
		digit_cnt = '0;
		code_acc  = '0;
		hi_bits   = '0;
		dropping  = 1'b0;
	endfunction

	function automatic dec_byte_t ok_byte(input logic [7:0] d);
		return '{data: d, last: 1'b0, err: ERR_NONE};
	endfunction

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b1, c[3:0]};
		if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			return {1'b1, c[3:0] + 4'd9};
		return 5'b0;
	endfunction

	function automatic void put_utf8(input logic [20:0] cp, ref dec_byte_t grp [$]);
		if (cp < 21'h80) begin
			grp.insert(grp.size(), ok_byte(cp[7:0]));
		end else if (cp < 21'h800) begin
			grp.insert(grp.size(), ok_byte({3'b110, cp[10:6]}));
			grp.insert(grp.size(), ok_byte({2'b10, cp[5:0]}));
		end else if (cp < 21'h10000) begin
			grp.insert(grp.size(), ok_byte({4'b1110, cp[15:12]}));
			grp.insert(grp.size(), ok_byte({2'b10, cp[11:6]}));
			grp.insert(grp.size(), ok_byte({2'b10, cp[5:0]}));
		end else begin
			grp.insert(grp.size(), ok_byte({5'b11110, cp[20:18]}));
			grp.insert(grp.size(), ok_byte({2'b10, cp[17:12]}));
			grp.insert(grp.size(), ok_byte({2'b10, cp[11:6]}));
			grp.insert(grp.size(), ok_byte({2'b10, cp[5:0]}));
		end
	endfunction

	function automatic void unescape_byte(input logic [7:0] c, input logic l,
		ref dec_byte_t grp [$]);
		err_t        fault;
		logic [4:0]  nib;
		logic [15:0] code;
		grp.delete();
		fault = ERR_NONE;
		if (dropping) begin
			if (l)
				clear_state();
			return;
		end
		case (dec_mode)
			MODE_ESC: begin
				dec_mode = MODE_PLAIN;
				case (c)
					CH_T:     grp.insert(grp.size(), ok_byte(8'h09));
					CH_B:     grp.insert(grp.size(), ok_byte(8'h08));
					CH_F:     grp.insert(grp.size(), ok_byte(8'h0C));
					CH_N:     grp.insert(grp.size(), ok_byte(8'h0A));
					CH_R:     grp.insert(grp.size(), ok_byte(8'h0D));
					CH_BSL:   grp.insert(grp.size(), ok_byte(CH_BSL));
					CH_SLASH: grp.insert(grp.size(), ok_byte(CH_SLASH));
					CH_QUOTE: grp.insert(grp.size(), ok_byte(CH_QUOTE));
					CH_U: begin
						code_acc  = '0;
						digit_cnt = '0;
						dec_mode  = MODE_HEX_HI;
					end
					default: ;
				endcase
			end
			MODE_HEX_HI, MODE_HEX_LO: begin
				nib = nibble_of(c);
				if (!nib[4]) begin
					fault = ERR_HEX;
				end else begin
					code     = {code_acc[11:0], nib[3:0]};
					code_acc = code;
					if (digit_cnt != 2'd3) begin
						digit_cnt++;
					end else if (dec_mode == MODE_HEX_HI) begin
						if (code >= HI_SURR_MIN && code <= HI_SURR_MAX) begin
							hi_bits  = code[9:0];
							dec_mode = MODE_BSL;
						end else begin
							put_utf8({5'b0, code}, grp);
							dec_mode = MODE_PLAIN;
						end
					end else if (code >= LO_SURR_MIN && code <= LO_SURR_MAX) begin
						put_utf8(SUPP_BASE + {1'b0, hi_bits, code[9:0]}, grp);
						dec_mode = MODE_PLAIN;
					end else begin
						fault = ERR_WRONG;
					end
				end
			end
			MODE_BSL: begin
				if (c == CH_BSL)
					dec_mode = MODE_UESC;
				else
					fault = ERR_MISSING;
			end
			MODE_UESC: begin
				if (c == CH_U) begin
					code_acc  = '0;
					digit_cnt = '0;
					dec_mode  = MODE_HEX_LO;
				end else begin
					fault = ERR_MISSING;
				end
			end
			default: begin
				if (c == CH_BSL)
					dec_mode = MODE_ESC;
				else
					grp.insert(grp.size(), ok_byte(c));
			end
		endcase
		if (fault == ERR_NONE && l && dec_mode != MODE_PLAIN)
			fault = (dec_mode == MODE_BSL) ? ERR_MISSING : ERR_TRUNC;
		if (fault != ERR_NONE) begin
			grp.delete();
			grp.insert(grp.size(), '{data: 8'h00, last: 1'b0, err: fault});
			clear_state();
			dropping = !l;
		end else if (l) begin
			clear_state();
		end
		if (grp.size() > 0)
			grp[grp.size()-1].last = 1'b1;
	endfunction

	function automatic void add(input logic [7:0] b);
		feed.insert(feed.size(), '{b, 1'b0, 1'b0, 8'h00, ERR_NONE});
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic void add_code(input logic [15:0] v);
		add(CH_BSL);
		add(CH_U);
		for (int i = 3; i >= 0; i--)
			add(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic logic [7:0] pick_except(input logic [7:0] no);
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == no);
		return c;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] c;
		logic [4:0] nb;
		do begin
			c  = 8'($urandom_range(0, 255));
			nb = nibble_of(c);
		end while (nb[4]);
		return c;
	endfunction

	function automatic logic [15:0] hi_code();
		return 16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
	endfunction

	function automatic logic [15:0] lo_code();
		return 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
	endfunction

	function automatic void add_string();
		int          n_tok;
		int          kind;
		bit          stop;
		logic [15:0] v;
		n_tok = $urandom_range(1, 6);
		stop  = 1'b0;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				add(8'($urandom_range(0, 255)));
		end else begin
			for (int t = 0; t < n_tok && !stop; t++) begin
				kind = $urandom_range(0, 99);
				if (kind < 30) begin
					add(pick_except(CH_BSL));
				end else if (kind < 45) begin
					add(CH_BSL);
					add(esc_set[$urandom_range(0, 7)]);
				end else if (kind < 50) begin
					add(CH_BSL);
					add(8'($urandom_range(0, 255)));
				end else if (kind < 70) begin
					case ($urandom_range(0, 3))
						0: v = 16'($urandom_range(0, 16'h7F));
						1: v = 16'($urandom_range(16'h80, 16'h7FF));
						2: begin
							v = 16'($urandom_range(16'h800, 16'hFFFF));
							if (v >= HI_SURR_MIN && v <= HI_SURR_MAX)
								v ^= 16'h0400;
						end
						default: v = lo_code();
					endcase
					add_code(v);
				end else if (kind < 85) begin
					add_code(hi_code());
					add_code(lo_code());
				end else begin
					case ($urandom_range(0, 5))
						0: begin
							add_code(hi_code());
							add(pick_except(CH_BSL));
						end
						1: begin
							add_code(hi_code());
							add(CH_BSL);
							add(pick_except(CH_U));
						end
						2: begin
							add_code(hi_code());
							v = 16'($urandom);
							if (v >= LO_SURR_MIN && v <= LO_SURR_MAX)
								v ^= 16'h8000;
							add_code(v);
						end
						3: begin
							add(CH_BSL);
							add(CH_U);
							repeat ($urandom_range(0, 3))
								add(hex_char(4'($urandom)));
							add(non_hex());
						end
						4: begin
							add(CH_BSL);
							if ($urandom_range(0, 1)) begin
								add(CH_U);
								repeat ($urandom_range(0, 3))
									add(hex_char(4'($urandom)));
							end
							stop = 1'b1;
						end
						default: begin
							add_code(hi_code());
							if ($urandom_range(0, 1)) begin
								add(CH_BSL);
								if ($urandom_range(0, 1))
									add(CH_U);
							end
							stop = 1'b1;
						end
					endcase
				end
			end
		end
		feed[feed.size()-1].l = 1'b1;
	endfunction

	task automatic flag_result(input string why, input dec_byte_t want, input dec_byte_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %h last %b err %0d, got %h last %b err %0d", $time, why,
				want.data, want.last, want.err, got.data, got.last, got.err);
	endtask

	always @(posedge clk) begin : watch
		dec_byte_t grp [$];
		dec_byte_t want;
		dec_byte_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.out_byte, out_ch.out_last, err_t'(out_ch.out_error)};
				if (utf8_expect.size() == 0) begin
					flag_result("unexpected byte", '0, got);
				end else begin
					want = utf8_expect.pop_front();
					if (want != got)
						flag_result("mismatch", want, got);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				unescape_byte(feed[taken].b, feed[taken].l, grp);
				if (feed[taken].typed)
					utf8_expect.insert(utf8_expect.size(),
						'{feed[taken].exp_b, 1'b1, feed[taken].exp_e});
				else
					foreach (grp[i])
						utf8_expect.insert(utf8_expect.size(), grp[i]);
				taken++;
			end
		end
	end

	always @(negedge clk) begin : stall_gen
		int          stretch;
		logic [15:0] stall_pat;
		bit [3:0]    phase;
		if (stretch <= 0) begin
			stretch   = $urandom_range(20, 80);
			stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		end
		stretch--;
		phase++;
		out_ch.ready <= stall_pat[phase];
	end

	task automatic send(input item_t it);
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= it.b;
		in_ch.in_last <= it.l;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain_hold();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (utf8_expect.size() != 0);
	endtask

	initial begin
		repeat (CYCLE_CAP) @(posedge clk);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int idx;
		int burst;
		int gap;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.in_last = 1'b0;
		out_ch.ready  = 1'b0;
		taken         = 0;
		mismatches    = 0;
		clear_state();
		foreach (directed[i])
			feed.insert(feed.size(), directed[i]);
		while (feed.size() < DIRECTED_N + RANDOM_N)
			add_string();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idx = 0;
		while (idx < feed.size()) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && idx < feed.size(); k++) begin
				if (idx == DIRECTED_N || idx == DIRECTED_N + RANDOM_N / 2)
					drain_hold();
				send(feed[idx]);
				idx++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		drain_hold();
		repeat (16) @(negedge clk);
		mismatches += utf8_expect.size();
		if (utf8_expect.size() != 0)
			$display("%0d expected bytes never arrived", utf8_expect.size());
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
